// ----- rtl/core/glrw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package glrw_pkg;

  // Bits in one glyph row; the leftmost pixel is bit ROW_BITS-1.
  localparam int ROW_BITS = 16;
  // Pixels drawn per row are capped by the row length and by sixteen.
  localparam int PIX_MAX = (ROW_BITS < 16) ? ROW_BITS : 16;
  localparam int PIX_W = $clog2(PIX_MAX);
  localparam int GW_W = 5;

  typedef logic [ROW_BITS-1:0] row_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [GW_W-1:0] gw_t;

  localparam gw_t GW_RESET = GW_W'(8);
  localparam gw_t PIX_MAX_GW = GW_W'(PIX_MAX);

  // Display register indexes.
  localparam logic [7:0] REG_Y = 8'h20;
  localparam logic [7:0] REG_X = 8'h21;
  localparam logic [7:0] REG_GRAM = 8'h22;

  // Access kinds.
  localparam logic KIND_REG = 1'b0;
  localparam logic KIND_GRAM = 1'b1;

  // Microcode step addresses.
  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_X = 2'd1;
  localparam logic [1:0] STEP_Y = 2'd2;
  localparam logic [1:0] STEP_GRAM = 2'd3;

  // Value selects for an emitted access.
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_GRAM = 2'd2;

  // Jump conditions; when false the step counter simply increments.
  localparam logic [1:0] COND_NONE = 2'd0;
  localparam logic [1:0] COND_ZERO_WIDTH = 2'd1;
  localparam logic [1:0] COND_NOT_LAST = 2'd2;

  // One microcode word.
  typedef struct packed {
    logic       take_in;
    logic       emit;
    logic       adv;
    logic [1:0] sel;
    logic [1:0] cond;
    logic [1:0] target;
  } uword_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic       load;
    logic       emit;
    logic       adv;
    logic [1:0] sel;
  } ctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic zero_width;
    logic last_pix;
    logic can_emit;
  } stat_t;

  // Control store. The last step falls through to the idle step when the
  // counter wraps, so the pixel loop costs three steps.
  function automatic uword_t ucode_rom(input logic [1:0] step);
    uword_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cond = COND_ZERO_WIDTH;
        w.target = STEP_IDLE;
      end
      STEP_X: begin
        w.emit = 1'b1;
        w.sel = SEL_X;
      end
      STEP_Y: begin
        w.emit = 1'b1;
        w.sel = SEL_Y;
      end
      STEP_GRAM: begin
        w.emit = 1'b1;
        w.adv = 1'b1;
        w.sel = SEL_GRAM;
        w.cond = COND_NOT_LAST;
        w.target = STEP_X;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/glrw_useq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glrw_useq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire glrw_pkg::stat_t stat,
  output glrw_pkg::ctl_t      ctl
);

  logic [1:0] step_r;
  logic [1:0] step_nxt;
  glrw_pkg::uword_t uw;
  logic go;
  logic jump;

  // Fetch the control word for the current step.
  assign uw = glrw_pkg::ucode_rom(step_r);

  // A step completes when its handshake side is free.
  always_comb begin
    if (uw.take_in) begin
      go = in_valid;
    end else if (uw.emit) begin
      go = stat.can_emit;
    end else begin
      go = 1'b1;
    end
  end

  // Evaluate the jump condition of this step.
  always_comb begin
    unique case (uw.cond)
      glrw_pkg::COND_ZERO_WIDTH: jump = stat.zero_width;
      glrw_pkg::COND_NOT_LAST:   jump = !stat.last_pix;
      default:                   jump = 1'b0;
    endcase
  end

  // Next step address.
  always_comb begin
    step_nxt = step_r;
    if (go) begin
      step_nxt = jump ? uw.target : step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= glrw_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Strobes to the datapath.
  assign in_stall = !uw.take_in;
  assign ctl.load = uw.take_in && go;
  assign ctl.emit = uw.emit && go;
  assign ctl.adv = uw.adv && go;
  assign ctl.sel = uw.sel;

endmodule

`default_nettype wire

// ----- rtl/core/glrw_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module glrw_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire glrw_pkg::ctl_t ctl,
  output glrw_pkg::stat_t     stat,
  input  wire logic           cfg_we,
  input  wire logic [4:0]     cfg_wdata,
  input  wire logic [15:0]    in_glyph_row,
  input  wire logic [15:0]    in_origin_x,
  input  wire logic [15:0]    in_origin_y,
  input  wire logic [4:0]     in_row_index,
  input  wire logic [7:0]     in_fg_red,
  input  wire logic [7:0]     in_fg_green,
  input  wire logic [7:0]     in_fg_blue,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_access_kind,
  output logic [7:0]          out_reg_addr,
  output logic [23:0]         out_access_value,
  output logic                out_last
);

  glrw_pkg::gw_t  glyph_width_r;
  glrw_pkg::gw_t  width_eff;
  glrw_pkg::row_t shreg_r;
  glrw_pkg::pix_t pix_r;
  glrw_pkg::pix_t wlast_r;
  logic [15:0]    x_r;
  logic [15:0]    y_r;
  logic [23:0]    color_r;
  logic           oval_r;
  logic           okind_r;
  logic [7:0]     oaddr_r;
  logic [23:0]    oval_data_r;
  logic           olast_r;
  logic           acc_kind;
  logic [7:0]     acc_addr;
  logic [23:0]    acc_value;
  logic           acc_last;

  // Width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r <= glrw_pkg::GW_RESET;
    end else if (cfg_we) begin
      glyph_width_r <= cfg_wdata;
    end
  end

  // Saturate the width to the pixels a row can hold.
  assign width_eff = (glyph_width_r > glrw_pkg::PIX_MAX_GW) ? glrw_pkg::PIX_MAX_GW
                                                            : glyph_width_r;

  // Row state: loaded on accept, stepped one pixel per loop pass.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shreg_r <= glrw_pkg::row_t'(in_glyph_row);
      x_r <= in_origin_x;
      y_r <= 16'(in_origin_y + 16'(in_row_index));
      color_r <= {in_fg_red, in_fg_green, in_fg_blue};
      pix_r <= '0;
      wlast_r <= glrw_pkg::pix_t'(width_eff - glrw_pkg::GW_W'(1));
    end else if (ctl.adv) begin
      shreg_r <= {shreg_r[glrw_pkg::ROW_BITS-2:0], 1'b0};
      x_r <= 16'(x_r + 16'd1);
      pix_r <= glrw_pkg::pix_t'(pix_r + glrw_pkg::PIX_W'(1));
    end
  end

  // Select the access for the current step.
  always_comb begin
    unique case (ctl.sel)
      glrw_pkg::SEL_X: begin
        acc_kind = glrw_pkg::KIND_REG;
        acc_addr = glrw_pkg::REG_X;
        acc_value = {8'h00, x_r};
      end
      glrw_pkg::SEL_Y: begin
        acc_kind = glrw_pkg::KIND_REG;
        acc_addr = glrw_pkg::REG_Y;
        acc_value = {8'h00, y_r};
      end
      default: begin
        acc_kind = glrw_pkg::KIND_GRAM;
        acc_addr = glrw_pkg::REG_GRAM;
        acc_value = shreg_r[glrw_pkg::ROW_BITS-1] ? color_r : 24'h000000;
      end
    endcase
  end

  assign acc_last = (ctl.sel == glrw_pkg::SEL_GRAM) && (pix_r == wlast_r);

  // Output register: refilled when empty or while its item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (ctl.emit) begin
      oval_r <= 1'b1;
    end else if (!out_stall) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      okind_r <= acc_kind;
      oaddr_r <= acc_addr;
      oval_data_r <= acc_value;
      olast_r <= acc_last;
    end
  end

  assign out_valid = oval_r;
  assign out_access_kind = okind_r;
  assign out_reg_addr = oaddr_r;
  assign out_access_value = oval_data_r;
  assign out_last = olast_r;

  // Status for the sequencer.
  assign stat.zero_width = (glyph_width_r == '0);
  assign stat.last_pix = (pix_r == wlast_r);
  assign stat.can_emit = !oval_r || !out_stall;

endmodule

`default_nettype wire

// ----- rtl/core/glyph_row_to_lcd_pixel_writes.sv -----
// The microcode sequencer takes a row in its idle step, then emits an X, Y and GRAM write for
// each drawn pixel; a zero width row stays in the idle step. It runs one step per cycle unless
// held, one access per emitting step, and each access is registered in the output register.
// Output stall holds the sequencer on its current emitting step while the output register is full.
// Reset (rst_n low at a clock edge) sets glyph_width to 8, the sequencer to its idle step
// and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module glyph_row_to_lcd_pixel_writes (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_glyph_row,
  input  wire logic [15:0] in_origin_x,
  input  wire logic [15:0] in_origin_y,
  input  wire logic [4:0]  in_row_index,
  input  wire logic [7:0]  in_fg_red,
  input  wire logic [7:0]  in_fg_green,
  input  wire logic [7:0]  in_fg_blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_access_kind,
  output logic [7:0]       out_reg_addr,
  output logic [23:0]      out_access_value,
  output logic             out_last
);

  glrw_pkg::ctl_t  ctl;
  glrw_pkg::stat_t stat;

  // Microcode sequencer.
  glrw_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Datapath and output register.
  glrw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_glyph_row     (in_glyph_row),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_row_index     (in_row_index),
    .in_fg_red        (in_fg_red),
    .in_fg_green      (in_fg_green),
    .in_fg_blue       (in_fg_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_access_kind  (out_access_kind),
    .out_reg_addr     (out_reg_addr),
    .out_access_value (out_access_value),
    .out_last         (out_last)
  );

  // A row with pixels to draw blocks the next item while it is worked.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !stat.zero_width) |=> in_stall)
    else $error("input taken while a row is still being drawn");

  // No access is generated in the step that takes an item.
  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (in_stall && !ctl.load))
    else $error("access generated in the idle step");

  // The final access of a row is always the colour write.
  a_last_is_gram: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_access_kind == glrw_pkg::KIND_GRAM &&
                                 out_reg_addr == glrw_pkg::REG_GRAM))
    else $error("last flag on a coordinate write");

endmodule

`default_nettype wire

// ----- tb/lcd_access_monitor.sv -----
`timescale 1ns / 1ps

// Watches both channels and the width register of the glyph row renderer.
// It works out the display accesses of every accepted row and compares the
// accesses that leave the block, in order, against them.
module lcd_access_monitor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [15:0]       in_glyph_row,
  input  logic [15:0]       in_origin_x,
  input  logic [15:0]       in_origin_y,
  input  logic [4:0]        in_row_index,
  input  logic [7:0]        in_fg_red,
  input  logic [7:0]        in_fg_green,
  input  logic [7:0]        in_fg_blue,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_access_kind,
  input  logic [7:0]        out_reg_addr,
  input  logic [23:0]       out_access_value,
  input  logic              out_last,
  output int unsigned       mismatch_count,
  output int unsigned       accesses_due
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  addr;
    logic [23:0] value;
    logic        last;
  } lcd_access_t;

  // Our own copy of the width register and the accesses still to come.
  glrw_pkg::gw_t glyph_width_q;
  lcd_access_t   pending_accesses[$];

  initial begin
    mismatch_count = 0;
    accesses_due = 0;
    glyph_width_q = glrw_pkg::GW_RESET;
  end

  // Queue the X, Y and GRAM writes for every drawn pixel of one row.
  function automatic void draw_row_accesses(input logic [15:0] row, input logic [15:0] ox,
                                            input logic [15:0] oy, input logic [4:0] ri,
                                            input logic [23:0] rgb);
    int          span;
    int          pos;
    logic        lit;
    logic [15:0] px;
    logic [15:0] py;
    lcd_access_t acc;
    span = int'(glyph_width_q);
    if (span > glrw_pkg::PIX_MAX) begin
      span = glrw_pkg::PIX_MAX;
    end
    py = oy + 16'(ri);
    for (int j = 0; j < span; j++) begin
      pos = glrw_pkg::ROW_BITS - 1 - j;
      lit = (pos < 16) ? row[pos] : 1'b0;
      px = ox + 16'(j);
      acc = '{kind: glrw_pkg::KIND_REG, addr: glrw_pkg::REG_X, value: {8'h00, px},
              last: 1'b0};
      pending_accesses.push_back(acc);
      acc = '{kind: glrw_pkg::KIND_REG, addr: glrw_pkg::REG_Y, value: {8'h00, py},
              last: 1'b0};
      pending_accesses.push_back(acc);
      acc = '{kind: glrw_pkg::KIND_GRAM, addr: glrw_pkg::REG_GRAM,
              value: (lit ? rgb : 24'h000000), last: (j == span - 1)};
      pending_accesses.push_back(acc);
    end
  endfunction

  // Predict on each accepted row, track the register and check each access.
  always @(posedge clk) begin
    lcd_access_t want;
    if (!rst_n) begin
      glyph_width_q = glrw_pkg::GW_RESET;
      pending_accesses.delete();
    end else begin
      // A row accepted at this edge still sees the width from before it.
      if (in_valid && !in_stall) begin
        draw_row_accesses(in_glyph_row, in_origin_x, in_origin_y, in_row_index,
                          {in_fg_red, in_fg_green, in_fg_blue});
      end
      if (cfg_we) begin
        glyph_width_q = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (pending_accesses.size() == 0) begin
          mismatch_count++;
          $error("unexpected access: kind %0d addr %02h value %06h last %0d",
                 out_access_kind, out_reg_addr, out_access_value, out_last);
        end else begin
          want = pending_accesses.pop_front();
          if (out_access_kind !== want.kind) begin
            mismatch_count++;
            $error("access_kind: expected %0d, got %0d", want.kind, out_access_kind);
          end
          if (out_reg_addr !== want.addr) begin
            mismatch_count++;
            $error("reg_addr: expected %02h, got %02h", want.addr, out_reg_addr);
          end
          if (out_access_value !== want.value) begin
            mismatch_count++;
            $error("access_value: expected %06h, got %06h", want.value, out_access_value);
          end
          if (out_last !== want.last) begin
            mismatch_count++;
            $error("last: expected %0d, got %0d", want.last, out_last);
          end
        end
      end
    end
    accesses_due = pending_accesses.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Cycles to let a row that draws nothing drain before touching the register.
  localparam int DRAIN_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_glyph_row;
  logic [15:0] in_origin_x;
  logic [15:0] in_origin_y;
  logic [4:0]  in_row_index;
  logic [7:0]  in_fg_red;
  logic [7:0]  in_fg_green;
  logic [7:0]  in_fg_blue;
  logic        out_valid;
  logic        out_stall;
  logic        out_access_kind;
  logic [7:0]  out_reg_addr;
  logic [23:0] out_access_value;
  logic        out_last;
  int unsigned mismatch_count;
  int unsigned accesses_due;
  int          quiet_cycles;
  bit          no_gaps;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  glyph_row_to_lcd_pixel_writes dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_glyph_row     (in_glyph_row),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_row_index     (in_row_index),
    .in_fg_red        (in_fg_red),
    .in_fg_green      (in_fg_green),
    .in_fg_blue       (in_fg_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_access_kind  (out_access_kind),
    .out_reg_addr     (out_reg_addr),
    .out_access_value (out_access_value),
    .out_last         (out_last)
  );

  lcd_access_monitor monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_glyph_row     (in_glyph_row),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_row_index     (in_row_index),
    .in_fg_red        (in_fg_red),
    .in_fg_green      (in_fg_green),
    .in_fg_blue       (in_fg_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_access_kind  (out_access_kind),
    .out_reg_addr     (out_reg_addr),
    .out_access_value (out_access_value),
    .out_last         (out_last),
    .mismatch_count   (mismatch_count),
    .accesses_due     (accesses_due)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) begin
      return 0;
    end else if (p < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offer one row and hold it until the block takes it.
  task automatic draw_row(input logic [15:0] row, input logic [15:0] ox,
                          input logic [15:0] oy, input logic [4:0] ri,
                          input logic [23:0] rgb);
    in_valid <= 1'b1;
    in_glyph_row <= row;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_row_index <= ri;
    {in_fg_red, in_fg_green, in_fg_blue} <= rgb;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // A random row: solid, empty or arbitrary bits, at times placed near the wrap point.
  task automatic draw_random_row();
    int          p;
    logic [15:0] row;
    logic [15:0] ox;
    logic [15:0] oy;
    p = $urandom_range(0, 9);
    row = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);
    ox = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                     : 16'($urandom);
    oy = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(16'hFFE0, 16'hFFFF))
                                     : 16'($urandom);
    draw_row(row, ox, oy, 5'($urandom_range(0, 31)), 24'($urandom));
  endtask

  // Change the width only once every expected access is out and the block is idle.
  task automatic set_glyph_width(input logic [4:0] w);
    in_valid <= 1'b0;
    do @(negedge clk); while (accesses_due != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Output back-pressure, with occasional long free-flowing stretches.
  initial begin : out_stall_gen
    int s;
    out_stall <= 1'b0;
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 120)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        s = pick_gap();
        if (s > 0) begin
          out_stall <= 1'b1;
          repeat (s) @(negedge clk);
        end
      end
    end
  end

  // Hang detection: no item accepted on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int gap;
    logic [4:0] w;
    quiet_cycles = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_glyph_row <= '0;
    in_origin_x <= '0;
    in_origin_y <= '0;
    in_row_index <= '0;
    in_fg_red <= '0;
    in_fg_green <= '0;
    in_fg_blue <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset width of eight: solid and empty rows, both coordinates wrapping,
    // set bits that fall outside the drawn width, and pure primary colours.
    draw_row(16'hFFFF, 16'h0000, 16'h0000, 5'd0, 24'hFFFFFF);
    draw_row(16'h0000, 16'hFFFF, 16'hFFFF, 5'd31, 24'h000000);
    draw_row(16'h8001, 16'hFFFC, 16'hFFF0, 5'd15, 24'h123456);
    draw_row(16'h00FF, 16'h1234, 16'h4321, 5'd3, 24'hFFFFFF);
    draw_row(16'hA500, 16'h0010, 16'h0020, 5'd1, 24'hFF0000);
    draw_row(16'h5A00, 16'h7FFF, 16'h8000, 5'd16, 24'h00FF00);
    draw_row(16'hC300, 16'hFFF9, 16'h0000, 5'd30, 24'h0000FF);

    // Full width.
    set_glyph_width(5'd16);
    draw_row(16'hFFFF, 16'hFFF8, 16'hFFFE, 5'd2, 24'hABCDEF);
    draw_row(16'h0001, 16'h0000, 16'h0000, 5'd0, 24'hFFFFFF);
    draw_row(16'hAAAA, 16'h5555, 16'hAAAA, 5'd21, 24'h5A5A5A);
    draw_row(16'h5555, 16'hAAAA, 16'h5555, 5'd10, 24'hA5A5A5);

    // Width past the row length is capped at sixteen pixels.
    set_glyph_width(5'd31);
    draw_row(16'hFFFF, 16'hFFF1, 16'hFFFF, 5'd31, 24'hFFFFFF);
    draw_row(16'h8001, 16'h0100, 16'h0200, 5'd7, 24'h010203);
    set_glyph_width(5'd17);
    draw_row(16'h0F0F, 16'h0300, 16'h0400, 5'd9, 24'hFEDCBA);

    // Zero width draws nothing.
    set_glyph_width(5'd0);
    draw_row(16'hFFFF, 16'h0000, 16'h0000, 5'd0, 24'hFFFFFF);
    draw_row(16'h1234, 16'hFFFF, 16'hFFFF, 5'd31, 24'h00FF00);

    // Single pixel.
    set_glyph_width(5'd1);
    draw_row(16'h8000, 16'hFFFF, 16'hFFFF, 5'd31, 24'hFFFFFF);
    draw_row(16'h7FFF, 16'h0000, 16'h0000, 5'd0, 24'hFFFFFF);

    // Random phases, each under its own width; some phases offer their rows back to back.
    for (int phase = 0; phase < 11; phase++) begin
      case (phase)
        0: w = 5'd16;
        1: w = 5'd1;
        2: w = 5'd0;
        3: w = 5'd31;
        4: w = 5'd8;
        default: w = 5'($urandom_range(0, 31));
      endcase
      set_glyph_width(w);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 27; n++) begin
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        draw_random_row();
      end
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    do @(negedge clk); while (accesses_due != 0);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/glrw_pkg.sv
rtl/core/glrw_useq.sv
rtl/core/glrw_dp.sv
rtl/core/glyph_row_to_lcd_pixel_writes.sv
tb/lcd_access_monitor.sv
tb/tb_top.sv
